FILE: rtl/okvt_pkg.sv
// Shared codes, widths and control types for the ordered key/value table.
`timescale 1ns / 1ps
`default_nettype none

package okvt_pkg;

    // Fixed port widths.
    localparam int KEY_PORT_W = 64;
    localparam int VALUE_W    = 64;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;

    // Operation codes on the mode port.
    localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Status codes on the status port.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Per-cycle commands broadcast from the controller to every cell.
    typedef struct packed {
        logic put_en;
        logic remove_en;
    } okvt_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/okvt_cell.sv
// One table slot: holds a key/value pair, compares it and shifts from its neighbor.
`timescale 1ns / 1ps
`default_nettype none

module okvt_cell #(
    parameter int KEY_W = 64,
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  wire logic                            clk,
    input  wire okvt_pkg::okvt_ctrl_t            ctrl,
    input  wire logic [CNT_W-1:0]                count,
    input  wire logic [KEY_W-1:0]                search_key,
    input  wire logic [okvt_pkg::VALUE_W-1:0]    put_value,
    input  wire logic [KEY_W-1:0]                next_key,
    input  wire logic [okvt_pkg::VALUE_W-1:0]    next_value,
    input  wire logic                            hit_in,
    input  wire logic [okvt_pkg::VALUE_W-1:0]    chain_in,
    output logic      [KEY_W-1:0]                key_q,
    output logic      [okvt_pkg::VALUE_W-1:0]    value_q,
    output logic                                 hit_out,
    output logic      [okvt_pkg::VALUE_W-1:0]    chain_out
);

    logic [KEY_W-1:0]             key_reg;
    logic [KEY_W-1:0]             key_next;
    logic [okvt_pkg::VALUE_W-1:0] value_reg;
    logic [okvt_pkg::VALUE_W-1:0] value_next;
    logic                         live;
    logic                         match;
    logic                         first;
    logic                         at_tail;

    // The slot holds a live entry when its position is below the fill count.
    assign live    = CNT_W'(INDEX) < count;
    assign at_tail = CNT_W'(INDEX) == count;
    assign match   = live && (key_reg == search_key);
    assign first   = match && !hit_in;

    // Priority chain: the earliest matching slot drives its value down the row.
    assign hit_out   = hit_in || match;
    assign chain_out = chain_in | (first ? value_reg : '0);

    assign key_q   = key_reg;
    assign value_q = value_reg;

    // A put writes the tail slot; a remove pulls every slot from the match onward.
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.put_en && at_tail)
        begin
            key_next   = search_key;
            value_next = put_value;
        end
        else if (ctrl.remove_en && (hit_in || match))
        begin
            key_next   = next_key;
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

FILE: rtl/ordered_key_value_table.sv
// Top level of the ordered key/value table: command port, controller and row of cells.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A command word (mode, key, value) is taken at a rising edge where start is
// high and busy is low. mode 0 appends the pair, mode 1 looks up the earliest
// entry with that key, mode 2 returns and deletes that entry, closing the gap
// so later entries keep their order. Only the low KEY_BYTES bytes of key are
// stored and compared.
// Each command yields one result word (status, value_out), shown for exactly
// one cycle with done high; the receiver cannot stall it.
// The command is executed in the cycle after acceptance, and the
// result appears in the cycle after that. busy is high during the execute
// cycle only, and no new command is taken while one executes; each command
// takes a single execute pass over the row of ENTRIES cells.
// Reset clears the fill count and the control flags; the table is empty
// afterward and no clearing pass is needed.

module ordered_key_value_table #(
    parameter int ENTRIES   = 16,
    parameter int KEY_BYTES = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [okvt_pkg::MODE_W-1:0]         mode,
    input  wire logic [okvt_pkg::KEY_PORT_W-1:0]     key,
    input  wire logic [okvt_pkg::VALUE_W-1:0]        value,
    output logic                                     done,
    output logic      [okvt_pkg::STATUS_W-1:0]       status,
    output logic      [okvt_pkg::VALUE_W-1:0]        value_out
);

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic                             busy_reg;
    logic                             busy_next;
    logic [okvt_pkg::MODE_W-1:0]      mode_reg;
    logic [KEY_W-1:0]                 key_reg;
    logic [okvt_pkg::VALUE_W-1:0]     value_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic                             done_reg;
    logic [okvt_pkg::STATUS_W-1:0]    status_reg;
    logic [okvt_pkg::STATUS_W-1:0]    status_next;
    logic [okvt_pkg::VALUE_W-1:0]     value_out_reg;
    logic [okvt_pkg::VALUE_W-1:0]     value_out_next;

    logic                             accept;
    logic                             full;
    logic                             found;
    logic                             is_put;
    logic                             is_find;
    okvt_pkg::okvt_ctrl_t             ctrl;

    logic [KEY_W-1:0]                 cell_key   [ENTRIES];
    logic [okvt_pkg::VALUE_W-1:0]     cell_value [ENTRIES];
    logic [ENTRIES:0]                 hit_w;
    logic [okvt_pkg::VALUE_W-1:0]     chain_w    [ENTRIES+1];

    assign accept  = start && !busy_reg;
    assign full    = count_reg == CNT_W'(ENTRIES);
    assign is_put  = mode_reg == okvt_pkg::MODE_PUT;
    assign is_find = (mode_reg == okvt_pkg::MODE_GET) || (mode_reg == okvt_pkg::MODE_REMOVE);
    assign found   = hit_w[ENTRIES];

    // Commands to the cells are live only in the execute cycle.
    assign ctrl.put_en    = busy_reg && is_put && !full;
    assign ctrl.remove_en = busy_reg && (mode_reg == okvt_pkg::MODE_REMOVE);

    // Row of cells; the last cell pulls from itself since its slot dies on remove.
    assign hit_w[0]   = 1'b0;
    assign chain_w[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [KEY_W-1:0]             nkey;
        logic [okvt_pkg::VALUE_W-1:0] nvalue;

        if (i == ENTRIES - 1)
        begin : g_last
            assign nkey   = cell_key[i];
            assign nvalue = cell_value[i];
        end
        else
        begin : g_mid
            assign nkey   = cell_key[i+1];
            assign nvalue = cell_value[i+1];
        end

        okvt_cell #(
            .KEY_W (KEY_W),
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .search_key (key_reg),
            .put_value  (value_reg),
            .next_key   (nkey),
            .next_value (nvalue),
            .hit_in     (hit_w[i]),
            .chain_in   (chain_w[i]),
            .key_q      (cell_key[i]),
            .value_q    (cell_value[i]),
            .hit_out    (hit_w[i+1]),
            .chain_out  (chain_w[i+1])
        );
    end

    // Result word and fill count for the command in execution.
    always_comb
    begin
        busy_next      = busy_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        if (busy_reg)
        begin
            busy_next      = 1'b0;
            status_next    = okvt_pkg::ST_NOT_FOUND;
            value_out_next = '0;
            if (is_put)
            begin
                if (full)
                begin
                    status_next = okvt_pkg::ST_FULL;
                end
                else
                begin
                    status_next = okvt_pkg::ST_OK;
                    count_next  = count_reg + 1'b1;
                end
            end
            else if (is_find && found)
            begin
                status_next    = okvt_pkg::ST_OK;
                value_out_next = chain_w[ENTRIES];
                if (ctrl.remove_en)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        end
        else if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            status_reg    <= okvt_pkg::ST_OK;
            value_out_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            done_reg      <= busy_reg;
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
        end
    end

    // Command word capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            key_reg   <= key[KEY_W-1:0];
            value_reg <= value;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;

    // A result follows exactly one execute cycle.
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("result strobe without an execute cycle");

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("fill count above table size");

    // A refused put leaves the table untouched.
    a_full_stable: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == okvt_pkg::ST_FULL) |-> $stable(count_reg))
        else $error("fill count changed on a refused put");

    // A successful remove drops exactly one entry.
    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == okvt_pkg::ST_OK) && (mode_reg == okvt_pkg::MODE_REMOVE)
        |-> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("remove did not drop exactly one entry");

endmodule

`default_nettype wire
